>>> hdl/firch_pkg.sv
`timescale 1ns / 1ps

package firch_pkg;

	// Default sizes, handed to the top level as parameter defaults
	localparam int MAX_TAPS_DEF    = 64;
	localparam int FRAC_BITS_DEF   = 14;

	// Field widths of the request and result channels, and of the accumulator
	localparam int SAMPLE_W        = 16;
	localparam int COEF_W          = 16;
	localparam int COEF_IDX_W      = 6;
	localparam int OUT_W           = 18;
	localparam int ACC_W           = 32;

	// Register port
	localparam int PADDR_W         = 3;
	localparam int PDATA_W         = 32;
	localparam int TAP_W           = 7;
	localparam int TAP_COUNT_RESET = 64;
	localparam logic REG_TAP_COUNT = 1'b0;

	// Operation codes
	localparam logic OP_FILTER     = 1'b0;
	localparam logic OP_LOAD       = 1'b1;

	// Control that travels with one memory read into the MAC pipeline
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

endpackage

>>> hdl/fir_filter_circular_history_core.sv
`timescale 1ns / 1ps

// Channel   | Handshake                    | Payload
// ----------+------------------------------+-------------------------------------------
// item      | item_valid / item_ready      | operation, sample, coef_index, coef_value
// result    | result_valid / result_ready  | filtered
// register  | psel, penable, pwrite, pready | paddr, pwdata, prdata (tap_count at 0x0)
//
// A coefficient load leaves item_ready high. A sample runs one multiply-accumulate per tap,
// paced by the single read port of each memory, then drains the MAC pipeline; item_ready
// stays low until the core is back in idle, so a new sample waits for the last one.
// After reset the history memory is swept to zero, one entry at a time, while item_ready is low.
// A stalled result waits in the output register; the core finishes the next sample and holds
// its sum until that register frees.

module fir_filter_circular_history_core #(
	parameter int MAX_TAPS  = firch_pkg::MAX_TAPS_DEF,
	parameter int FRAC_BITS = firch_pkg::FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// request channel
	input  logic                                    item_valid,
	output logic                                    item_ready,
	input  logic                                    operation,
	input  logic signed [firch_pkg::SAMPLE_W-1:0]   sample,
	input  logic [firch_pkg::COEF_IDX_W-1:0]        coef_index,
	input  logic signed [firch_pkg::COEF_W-1:0]     coef_value,
	// result channel
	output logic                                    result_valid,
	input  logic                                    result_ready,
	output logic signed [firch_pkg::OUT_W-1:0]      filtered,
	// register port
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [firch_pkg::PADDR_W-1:0]           paddr,
	input  logic [firch_pkg::PDATA_W-1:0]           pwdata,
	output logic [firch_pkg::PDATA_W-1:0]           prdata,
	output logic                                    pready
);

	import firch_pkg::*;

	localparam int IDX_W   = $clog2(MAX_TAPS);
	localparam int CNT_W   = $clog2(MAX_TAPS + 1);
	localparam int TAP_RST = (MAX_TAPS < TAP_COUNT_RESET) ? MAX_TAPS : TAP_COUNT_RESET;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_PUSH  = 3'd4;

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        tap_q;
	logic [IDX_W-1:0]        oldest_q;
	logic [IDX_W-1:0]        rd_pos_q;
	logic [IDX_W-1:0]        cnt_q;
	logic [IDX_W-1:0]        clr_q;
	logic                    result_valid_q;
	logic signed [OUT_W-1:0] filtered_q;

	logic                    cfg_we;
	logic [TAP_W-1:0]        tap_wr;
	logic [CNT_W-1:0]        tap_sat;
	logic [CNT_W-1:0]        tap_m1;
	logic [IDX_W-1:0]        tap_last;
	logic [IDX_W-1:0]        wr_pos;
	logic [IDX_W-1:0]        wr_pos_inc;
	logic                    accept;
	logic                    take_sample;
	logic                    take_coef;
	logic                    out_free;
	logic                    push_go;

	logic                    hist_we;
	logic [IDX_W-1:0]        hist_waddr;
	logic [SAMPLE_W-1:0]     hist_wdata;
	logic [SAMPLE_W-1:0]     hist_rdata;
	logic [COEF_W-1:0]       coef_rdata;

	mac_ctl_t                issue;
	logic                    mac_done;
	logic signed [ACC_W-1:0] mac_acc;
	logic signed [ACC_W-1:0] acc_sh;

	// ---------------------------------------------------------------------------------------
	// Register port: tap_count saturates into 1..MAX_TAPS and rewinds the write position
	// ---------------------------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_TAP_COUNT);
	assign tap_wr = pwdata[TAP_W-1:0];
	assign prdata = (paddr[2] == REG_TAP_COUNT) ? PDATA_W'(tap_q) : '0;

	always_comb begin
		priority if (tap_wr == '0) begin
			tap_sat = CNT_W'(1);
		end else if (32'(tap_wr) > 32'(MAX_TAPS)) begin
			tap_sat = CNT_W'(MAX_TAPS);
		end else begin
			tap_sat = CNT_W'(tap_wr);
		end
	end

	// ---------------------------------------------------------------------------------------
	// Circular position arithmetic
	// ---------------------------------------------------------------------------------------
	assign tap_m1     = tap_q - CNT_W'(1);
	assign tap_last   = tap_m1[IDX_W-1:0];
	// a position beyond the live length restarts at the front
	assign wr_pos     = (32'(oldest_q) >= 32'(tap_q)) ? '0 : oldest_q;
	assign wr_pos_inc = (wr_pos == tap_last) ? '0 : wr_pos + IDX_W'(1);

	assign item_ready  = (state_q == ST_IDLE);
	assign accept      = item_valid && item_ready;
	assign take_sample = accept && (operation == OP_FILTER);
	// loads beyond the store are dropped
	assign take_coef   = accept && (operation == OP_LOAD) &&
	                     (32'(coef_index) < 32'(MAX_TAPS));

	assign out_free = !result_valid_q || result_ready;
	assign push_go  = ((state_q == ST_DRAIN && mac_done) || state_q == ST_PUSH) && out_free;

	// ---------------------------------------------------------------------------------------
	// Sequencer: clear sweep, then per sample one read of each memory per tap
	// ---------------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			tap_q    <= CNT_W'(TAP_RST);
			oldest_q <= '0;
			rd_pos_q <= '0;
			cnt_q    <= '0;
			clr_q    <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(MAX_TAPS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take_sample) begin
						oldest_q <= wr_pos_inc;
						// newest sample first, paired with h[0]
						rd_pos_q <= wr_pos;
						cnt_q    <= '0;
						state_q  <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q    <= cnt_q + IDX_W'(1);
					rd_pos_q <= (rd_pos_q == '0) ? tap_last : rd_pos_q - IDX_W'(1);
					if (cnt_q == tap_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (mac_done) begin
						state_q <= push_go ? ST_IDLE : ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_we) begin
				tap_q    <= tap_sat;
				oldest_q <= '0;
			end
		end
	end

	// ---------------------------------------------------------------------------------------
	// Memories
	// ---------------------------------------------------------------------------------------
	assign hist_we    = (state_q == ST_CLEAR) || take_sample;
	assign hist_waddr = (state_q == ST_CLEAR) ? clr_q : wr_pos;
	assign hist_wdata = (state_q == ST_CLEAR) ? '0 : sample;

	firch_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_TAPS)
	) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.raddr (rd_pos_q),
		.rdata (hist_rdata)
	);

	firch_ram #(
		.WIDTH (COEF_W),
		.DEPTH (MAX_TAPS)
	) u_coef (
		.clk   (clk),
		.we    (take_coef),
		.waddr (IDX_W'(coef_index)),
		.wdata (coef_value),
		.raddr (cnt_q),
		.rdata (coef_rdata)
	);

	// ---------------------------------------------------------------------------------------
	// Multiply-accumulate
	// ---------------------------------------------------------------------------------------
	assign issue.valid = (state_q == ST_RUN);
	assign issue.first = (cnt_q == '0);
	assign issue.last  = (cnt_q == tap_last);

	firch_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (issue),
		.hist_data (signed'(hist_rdata)),
		.coef_data (signed'(coef_rdata)),
		.done      (mac_done),
		.acc       (mac_acc)
	);

	// ---------------------------------------------------------------------------------------
	// Output register: drop the fraction bits, keep the low result bits
	// ---------------------------------------------------------------------------------------
	assign acc_sh = mac_acc >>> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (push_go) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_go) begin
			filtered_q <= acc_sh[OUT_W-1:0];
		end
	end

	assign result_valid = result_valid_q;
	assign filtered     = filtered_q;

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == ST_DRAIN))
		else $error("sum completed outside drain");

	a_cfg_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (oldest_q == '0))
		else $error("write position not rewound");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(tap_q != '0) && (32'(oldest_q) < 32'(tap_q)))
		else $error("write position or tap count out of range");

	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		take_sample |=> (state_q == ST_RUN) && (cnt_q == '0))
		else $error("accepted sample did not start accumulation");

endmodule

>>> hdl/firch_ram.sv
`timescale 1ns / 1ps

module firch_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/firch_mac.sv
`timescale 1ns / 1ps

module firch_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  firch_pkg::mac_ctl_t                   ctl,
	input  logic signed [firch_pkg::SAMPLE_W-1:0] hist_data,
	input  logic signed [firch_pkg::COEF_W-1:0]   coef_data,
	output logic                                  done,
	output logic signed [firch_pkg::ACC_W-1:0]    acc
);

	import firch_pkg::*;

	mac_ctl_t                 ctl_s1;
	mac_ctl_t                 ctl_s2;
	logic signed [ACC_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     done_q;

	// Align control with the registered memory read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	// Exact 16x16 product, then a wrapping 32-bit accumulate
	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			prod_s2 <= ACC_W'(hist_data * coef_data);
		end
		if (ctl_s2.valid) begin
			acc_q <= (ctl_s2.first ? '0 : acc_q) + prod_s2;
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

	a_last_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s2.valid && ctl_s2.last) |=> done_q)
		else $error("accumulation end not flagged");

	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !ctl_s2.valid)
		else $error("product arrived after final tap");

endmodule
